/* sv/sacl_pkg.sv */
// Shared constants, types and codes of the set-associative tag directory.
`default_nettype none

package sacl_pkg;

  localparam int unsigned SET_COUNT  = 256;
  localparam int unsigned WAY_COUNT  = 8;
  localparam int unsigned LINE_BYTES = 64;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned WAY_W    = 4;
  localparam int unsigned AGE_W    = 16;
  localparam int unsigned OFFSET_W = $clog2(LINE_BYTES);
  localparam int unsigned SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int unsigned SET_USED = $clog2(SET_COUNT);
  localparam int unsigned TAG_W    = ADDR_W - OFFSET_W - SET_USED;
  localparam int unsigned CNT_W    = 32;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_INSERT = 2'd2
  } opcode_e;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } way_t;

  typedef way_t [WAY_COUNT-1:0] row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             filled;
    logic             evicted;
    logic             write;
    logic             count_hit;
    logic             count_miss;
  } pick_t;

endpackage

`default_nettype wire

/* sv/sacl_req_if.sv */
// Request channel: opcode and byte address.
`default_nettype none

interface sacl_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [sacl_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink (input valid, input opcode, input address, output ready);
endinterface

`default_nettype wire

/* sv/sacl_rsp_if.sv */
// Response channel: hit, way, fill status and running totals.
`default_nettype none

interface sacl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [sacl_pkg::WAY_W-1:0]   way;
  logic                         filled;
  logic                         evicted_valid;
  logic [sacl_pkg::CNT_W-1:0]   hit_total;
  logic [sacl_pkg::CNT_W-1:0]   miss_total;

  modport source (
    output valid, output hit, output way, output filled, output evicted_valid,
    output hit_total, output miss_total, input ready
  );
  modport sink (
    input valid, input hit, input way, input filled, input evicted_valid,
    input hit_total, input miss_total, output ready
  );
endinterface

`default_nettype wire

/* sv/set_assoc_cache_tags_age_lru.sv */
// Top level of the set-associative tag directory with age-counter replacement.
//
//   Channel | Direction | Payload
//   req_i   | in        | opcode, address
//   rsp_o   | out       | hit, way, filled, evicted_valid, hit_total, miss_total
//
// Each transaction has two steps: the set row is read from the tag memory into a register at
// acceptance, and the S_CALC step compares, selects a victim and writes the row back.
// A result waits in the output register while the next request is accepted.
// Reset clears the per-set row flags; a set never written reads as all zero.
// A stalled output holds the second transaction before its write-back.
`default_nettype none

module set_assoc_cache_tags_age_lru (
  input  logic       clk_i,
  input  logic       rst_ni,
  sacl_req_if.sink   req_i,
  sacl_rsp_if.source rsp_o
);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_e;

  state_e                          state_q;
  sacl_pkg::row_t                  tag_mem [sacl_pkg::SET_COUNT];
  sacl_pkg::row_t                  rd_row_q;
  sacl_pkg::row_t                  row_eff;
  sacl_pkg::row_t                  row_new;
  sacl_pkg::pick_t                 pick;
  logic [sacl_pkg::SET_COUNT-1:0]  row_init_q;
  logic                            init_q;
  logic [sacl_pkg::SET_W-1:0]      rd_set;
  logic [sacl_pkg::SET_W-1:0]      set_q;
  logic [sacl_pkg::TAG_W-1:0]      tag_q;
  sacl_pkg::opcode_e               op_q;
  logic                            accept;
  logic                            out_free;
  logic                            commit;
  logic [sacl_pkg::CNT_W-1:0]      hit_cnt_q;
  logic [sacl_pkg::CNT_W-1:0]      hit_cnt_d;
  logic [sacl_pkg::CNT_W-1:0]      miss_cnt_q;
  logic [sacl_pkg::CNT_W-1:0]      miss_cnt_d;
  logic                            out_valid_q;
  sacl_pkg::pick_t                 out_q;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign commit   = (state_q == S_CALC) && out_free;
  assign req_i.ready = (state_q == S_IDLE);

  if (sacl_pkg::SET_USED > 0) begin : g_set
    assign rd_set = req_i.address[sacl_pkg::OFFSET_W +: sacl_pkg::SET_W];
  end else begin : g_one_set
    assign rd_set = '0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_row_q <= tag_mem[rd_set];
      set_q    <= rd_set;
      tag_q    <= req_i.address[sacl_pkg::ADDR_W-1 -: sacl_pkg::TAG_W];
      op_q     <= sacl_pkg::opcode_e'(req_i.opcode);
    end
    if (commit && pick.write) begin
      tag_mem[set_q] <= row_new;
    end
  end

  assign row_eff = init_q ? rd_row_q : '0;

  sacl_pick u_pick (
    .op_i  (op_q),
    .tag_i (tag_q),
    .row_i (row_eff),
    .res_o (pick),
    .row_o (row_new)
  );

  assign hit_cnt_d  = hit_cnt_q + sacl_pkg::CNT_W'(pick.count_hit);
  assign miss_cnt_d = miss_cnt_q + sacl_pkg::CNT_W'(pick.count_miss);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_init_q  <= '0;
      init_q      <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (accept) begin
        init_q <= row_init_q[rd_set];
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (commit) begin
        if (pick.write) begin
          row_init_q[set_q] <= 1'b1;
        end
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        out_q       <= pick;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = out_q.hit;
  assign rsp_o.way           = out_q.way;
  assign rsp_o.filled        = out_q.filled;
  assign rsp_o.evicted_valid = out_q.evicted;
  assign rsp_o.hit_total     = hit_cnt_q;
  assign rsp_o.miss_total    = miss_cnt_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request accepted while the previous one was still in flight");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> rsp_o.valid)
    else $error("finished transaction did not reach the output register");

  a_hit_not_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.filled))
    else $error("result reports both a hit and a fill");

  a_evict_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.evicted_valid |-> rsp_o.filled)
    else $error("eviction reported without a fill");
`endif

endmodule

`default_nettype wire

/* sv/sacl_pick.sv */
// Hit search, victim choice and age update for one set row.
`default_nettype none

module sacl_pick (
  input  sacl_pkg::opcode_e            op_i,
  input  logic [sacl_pkg::TAG_W-1:0]   tag_i,
  input  sacl_pkg::row_t               row_i,
  output sacl_pkg::pick_t              res_o,
  output sacl_pkg::row_t               row_o
);

  logic                           hit_found;
  logic [sacl_pkg::WAY_W-1:0]     hit_way;
  logic                           inv_found;
  logic [sacl_pkg::WAY_W-1:0]     inv_way;
  logic [sacl_pkg::AGE_W-1:0]     best_age;
  logic [sacl_pkg::WAY_W-1:0]     old_way;
  logic [sacl_pkg::WAY_W-1:0]     fill_way;
  logic                           touch;
  logic                           fill;
  logic [sacl_pkg::WAY_W-1:0]     touch_way;

  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = 0; w < sacl_pkg::WAY_COUNT; w++) begin
      if (!hit_found && row_i[w].valid && (row_i[w].tag == tag_i)) begin
        hit_found = 1'b1;
        hit_way   = sacl_pkg::WAY_W'(w);
      end
      if (!inv_found && !row_i[w].valid) begin
        inv_found = 1'b1;
        inv_way   = sacl_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    best_age = '0;
    old_way  = '0;
    for (int w = 0; w < sacl_pkg::WAY_COUNT; w++) begin
      if (w == 0 || row_i[w].age > best_age) begin
        best_age = row_i[w].age;
        old_way  = sacl_pkg::WAY_W'(w);
      end
    end
  end

  assign fill_way = inv_found ? inv_way : old_way;

  always_comb begin
    res_o     = '0;
    touch     = 1'b0;
    fill      = 1'b0;
    touch_way = '0;
    unique case (op_i)
      sacl_pkg::OP_ACCESS: begin
        res_o.count_hit  = hit_found;
        res_o.count_miss = !hit_found;
        touch            = 1'b1;
        fill             = !hit_found;
        touch_way        = hit_found ? hit_way : fill_way;
      end
      sacl_pkg::OP_LOOKUP: begin
        touch     = hit_found;
        touch_way = hit_way;
      end
      sacl_pkg::OP_INSERT: begin
        touch     = 1'b1;
        fill      = 1'b1;
        touch_way = fill_way;
      end
      default: begin
        touch = 1'b0;
      end
    endcase
    res_o.hit     = touch && !fill;
    res_o.way     = touch ? touch_way : '0;
    res_o.filled  = fill;
    res_o.evicted = fill && !inv_found;
    res_o.write   = touch;
  end

  always_comb begin
    for (int w = 0; w < sacl_pkg::WAY_COUNT; w++) begin
      row_o[w] = row_i[w];
      if (fill && touch_way == sacl_pkg::WAY_W'(w)) begin
        row_o[w].valid = 1'b1;
        row_o[w].tag   = tag_i;
        row_o[w].age   = '0;
      end else if (row_i[w].valid) begin
        if (touch_way == sacl_pkg::WAY_W'(w)) begin
          row_o[w].age = '0;
        end else if (row_i[w].age != '1) begin
          row_o[w].age = row_i[w].age + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the set-associative tag directory with age-based replacement.
import sacl_pkg::*;

typedef struct packed {
  logic             hit;
  logic [WAY_W-1:0] way;
  logic             filled;
  logic             evicted_valid;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
} dir_result_t;

class tag_dir_tracker;
  bit             line_valid [SET_COUNT][WAY_COUNT];
  bit [TAG_W-1:0] line_tag   [SET_COUNT][WAY_COUNT];
  bit [AGE_W-1:0] line_age   [SET_COUNT][WAY_COUNT];
  bit [CNT_W-1:0] hit_count;
  bit [CNT_W-1:0] miss_count;
  dir_result_t    pending_results [$];
  int unsigned    errors;

  function void touch(int unsigned set_idx, int unsigned way_idx);
    for (int unsigned w = 0; w < WAY_COUNT; w++) begin
      if (line_valid[set_idx][w]) begin
        if (w == way_idx) begin
          line_age[set_idx][w] = '0;
        end else if (line_age[set_idx][w] != '1) begin
          line_age[set_idx][w] = line_age[set_idx][w] + 1'b1;
        end
      end
    end
  endfunction

  function int match_way(int unsigned set_idx, bit [TAG_W-1:0] tag_val);
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag_val) begin
        return w;
      end
    end
    return -1;
  endfunction

  function int unsigned fill_victim(int unsigned set_idx, bit [TAG_W-1:0] tag_val,
                                    output bit evicted);
    int unsigned    victim;
    bit [AGE_W-1:0] oldest;
    victim  = 0;
    evicted = 1'b1;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (!line_valid[set_idx][w]) begin
        victim  = w;
        evicted = 1'b0;
      end
    end
    if (evicted) begin
      oldest = line_age[set_idx][0];
      for (int unsigned w = 1; w < WAY_COUNT; w++) begin
        if (line_age[set_idx][w] > oldest) begin
          oldest = line_age[set_idx][w];
          victim = w;
        end
      end
    end
    line_valid[set_idx][victim] = 1'b1;
    line_tag[set_idx][victim]   = tag_val;
    line_age[set_idx][victim]   = '0;
    touch(set_idx, victim);
    return victim;
  endfunction

  function void note_request(logic [1:0] op, logic [ADDR_W-1:0] addr);
    int unsigned    blk;
    int unsigned    set_idx;
    bit [TAG_W-1:0] tag_val;
    int             matched;
    int unsigned    victim;
    bit             evicted;
    dir_result_t    res;
    blk     = addr / LINE_BYTES;
    set_idx = blk % SET_COUNT;
    tag_val = TAG_W'(blk / SET_COUNT);
    res     = '0;
    case (op)
      OP_ACCESS: begin
        matched = match_way(set_idx, tag_val);
        if (matched >= 0) begin
          res.hit = 1'b1;
          res.way = WAY_W'(matched);
          hit_count++;
          touch(set_idx, matched);
        end else begin
          miss_count++;
          victim            = fill_victim(set_idx, tag_val, evicted);
          res.way           = WAY_W'(victim);
          res.filled        = 1'b1;
          res.evicted_valid = evicted;
        end
      end
      OP_LOOKUP: begin
        matched = match_way(set_idx, tag_val);
        if (matched >= 0) begin
          res.hit = 1'b1;
          res.way = WAY_W'(matched);
          touch(set_idx, matched);
        end
      end
      OP_INSERT: begin
        victim            = fill_victim(set_idx, tag_val, evicted);
        res.way           = WAY_W'(victim);
        res.filled        = 1'b1;
        res.evicted_valid = evicted;
      end
      default: begin
      end
    endcase
    res.hit_total  = hit_count;
    res.miss_total = miss_count;
    pending_results.push_back(res);
  endfunction

  function void compare_field(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  function void check_response(dir_result_t got);
    dir_result_t want;
    if (pending_results.size() == 0) begin
      $error("Response transaction arrived with no request outstanding.");
      errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("hit", want.hit, got.hit);
    compare_field("way", want.way, got.way);
    compare_field("filled", want.filled, got.filled);
    compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
    compare_field("hit_total", want.hit_total, got.hit_total);
    compare_field("miss_total", want.miss_total, got.miss_total);
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned HOLD_AFTER     = 100;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned AGE_HAMMER     = 24;
  localparam int unsigned SAT_SET        = 5;
  localparam int unsigned SAT_TAG_BASE   = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          idling_on;
  int unsigned quiet_cycles;
  int unsigned hot_sets [4];
  int unsigned hot_tags [12];

  tag_dir_tracker directory = new();

  sacl_req_if req ();
  sacl_rsp_if rsp ();

  set_assoc_cache_tags_age_lru uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ADDR_W-1:0] pack_address(int unsigned tag_val, int unsigned set_idx,
                                                     int unsigned offset);
    return ADDR_W'((tag_val * SET_COUNT + set_idx) * LINE_BYTES + offset);
  endfunction

  task automatic send_request(logic [1:0] op, logic [ADDR_W-1:0] addr);
    if (idling_on && $urandom_range(99) < 23) begin
      req.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 23);
    end
    req.valid   <= 1'b1;
    req.opcode  <= op;
    req.address <= addr;
    do @(posedge clk_i); while (!req.ready);
    directory.note_request(op, addr);
  endtask

  task automatic pause_until_drained();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (directory.pending_results.size() != 0);
  endtask

  task automatic random_item();
    int unsigned        pick;
    logic [1:0]         op;
    logic [ADDR_W-1:0]  addr;
    pick = $urandom_range(99);
    if (pick < 50) begin
      op = OP_ACCESS;
    end else if (pick < 72) begin
      op = OP_LOOKUP;
    end else if (pick < 93) begin
      op = OP_INSERT;
    end else begin
      op = OP_UNUSED;
    end
    if ($urandom_range(99) < 85) begin
      addr = pack_address(hot_tags[$urandom_range(11)], hot_sets[$urandom_range(3)],
                          $urandom_range(LINE_BYTES - 1));
    end else begin
      addr = $urandom();
    end
    send_request(op, addr);
  endtask

  initial begin
    int unsigned seen;
    bit          held;
    seen = 0;
    held = 1'b0;
    wait (rst_ni === 1'b0);
    rsp.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        directory.check_response({rsp.hit, rsp.way, rsp.filled, rsp.evicted_valid,
                                  rsp.hit_total, rsp.miss_total});
        seen++;
      end
      if (!held && seen >= HOLD_AFTER) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        rsp.ready <= !(idling_on && $urandom_range(99) < 23);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    int unsigned done_items;
    rst_ni      <= 1'b0;
    req.valid   <= 1'b0;
    req.opcode  <= OP_ACCESS;
    req.address <= '0;
    idling_on   = 1'b1;
    hot_sets[0] = 0;
    hot_sets[1] = SET_COUNT - 1;
    hot_sets[2] = $urandom_range(SET_COUNT - 1);
    hot_sets[3] = $urandom_range(SET_COUNT - 1);
    hot_tags[0] = 0;
    hot_tags[1] = (1 << TAG_W) - 1;
    for (int i = 2; i < 12; i++) begin
      hot_tags[i] = $urandom_range((1 << TAG_W) - 1);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Address extremes, a lookup miss, duplicate tags and the unused opcode.
    send_request(OP_ACCESS, 32'h0000_0000);
    send_request(OP_ACCESS, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_003F);
    send_request(OP_LOOKUP, 32'h0000_0010);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'h0000_0000);

    // Fill one set, then keep touching its newest way so that the others grow old.
    // The following fills must then evict by age.
    for (int unsigned w = 0; w < WAY_COUNT; w++) begin
      send_request(OP_ACCESS, pack_address(SAT_TAG_BASE + w, SAT_SET, w));
    end
    send_request(OP_ACCESS, pack_address(SAT_TAG_BASE, SAT_SET, 0));
    idling_on = 1'b0;
    for (int unsigned n = 0; n < AGE_HAMMER; n++) begin
      send_request(OP_LOOKUP, pack_address(SAT_TAG_BASE + WAY_COUNT - 1, SAT_SET,
                                           $urandom_range(LINE_BYTES - 1)));
    end
    idling_on = 1'b1;
    send_request(OP_INSERT, pack_address(SAT_TAG_BASE + WAY_COUNT, SAT_SET, 0));
    send_request(OP_ACCESS, pack_address(SAT_TAG_BASE + 1, SAT_SET, 0));
    send_request(OP_INSERT, pack_address(SAT_TAG_BASE + WAY_COUNT + 1, SAT_SET, 0));

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items == 600) begin
        pause_until_drained();
      end
      if (done_items == 700) begin
        idling_on = 1'b0;
      end
      if (done_items == 1000) begin
        idling_on = 1'b1;
      end
      random_item();
      done_items++;
    end

    req.valid <= 1'b0;
    do @(posedge clk_i); while (directory.pending_results.size() != 0);
    repeat (8) @(posedge clk_i);
    if (directory.errors == 0 && directory.pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/sacl_pkg.sv
sv/sacl_req_if.sv
sv/sacl_rsp_if.sv
sv/sacl_pick.sv
sv/set_assoc_cache_tags_age_lru.sv
dv/tb.sv
